// File: sv/ebss_pkg.sv
// Shared types and constants of the event batch sync sender.
package ebss_pkg;

  localparam logic [2:0] CMD_QUEUE   = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_PROCESS = 3'd2;
  localparam logic [2:0] CMD_ACK     = 3'd3;
  localparam logic [2:0] CMD_DISC    = 3'd4;

  localparam logic [1:0] CFG_BURST_CAP   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;

  localparam int CNT_DROPPED = 0;
  localparam int CNT_QUEUED  = 1;
  localparam int CNT_SYNCED  = 2;
  localparam int CNT_SYNCS   = 3;
  localparam int CNT_ERRORS  = 4;
  localparam int CNT_RETRIES = 5;
  localparam int NUM_CNT     = 6;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SENDING  = 3'd1,
    MODE_WAIT_ACK = 3'd2,
    MODE_DONE     = 3'd3,
    MODE_ERROR    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_QUEUE,
    OP_START,
    OP_PROCESS,
    OP_ACK,
    OP_DISC,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] payload;
    logic [31:0] conf;
    logic [15:0] ack;
    logic [31:0] now;
    logic [5:0]  link;
    logic [2:0]  sel;
  } req_t;

  typedef struct packed {
    logic [5:0]  burst_cap;
    logic [31:0] timeout_ms;
    logic [7:0]  max_retries;
  } cfg_t;

endpackage

// File: sv/ebss_in_if.sv
// Request channel of the event batch sync sender.
interface ebss_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] event_payload;
  logic [31:0] confirmed_seq;
  logic [15:0] ack_count;
  logic [31:0] now_ms;
  logic [5:0]  link_accepts;
  logic [2:0]  stat_select;

  modport source (
    output valid, command, event_payload, confirmed_seq, ack_count, now_ms,
           link_accepts, stat_select,
    input  ready
  );
  modport sink (
    input  valid, command, event_payload, confirmed_seq, ack_count, now_ms,
           link_accepts, stat_select,
    output ready
  );
endinterface

// File: sv/ebss_out_if.sv
// Result channel of the event batch sync sender.
interface ebss_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] event_seq;
  logic [63:0] event_data;
  logic [2:0]  sync_state;
  logic        status;
  logic [31:0] value;
  logic [3:0]  pending;
  logic [31:0] newest_seq;
  logic [31:0] stat_value;
  logic        last;

  modport source (
    output valid, item_kind, event_seq, event_data, sync_state, status, value,
           pending, newest_seq, stat_value, last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, event_seq, event_data, sync_state, status, value,
           pending, newest_seq, stat_value, last,
    output ready
  );
endinterface

// File: sv/ebss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ebss_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: sv/ebss_front.sv
// Front end: accepts requests, decodes the command and queues them.
module ebss_front import ebss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ebss_in_if.sink in_req,
  output req_t  req,
  output logic  req_valid,
  input  logic  req_ready
);
  req_t       fifo_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  req_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.payload = in_req.event_payload;
    dec.conf    = in_req.confirmed_seq;
    dec.ack     = in_req.ack_count;
    dec.now     = in_req.now_ms;
    dec.link    = in_req.link_accepts;
    dec.sel     = in_req.stat_select;
    unique case (in_req.command)
      CMD_QUEUE:   dec.op = OP_QUEUE;
      CMD_START:   dec.op = OP_START;
      CMD_PROCESS: dec.op = OP_PROCESS;
      CMD_ACK:     dec.op = OP_ACK;
      CMD_DISC:    dec.op = OP_DISC;
      default:     dec.op = OP_NONE;
    endcase
  end

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;
  assign req_valid    = (cnt_r != 2'd0);
  assign req          = fifo_r[rp_r];
  assign pop          = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wp_r] <= dec;
        wp_r         <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: sv/ebss_back.sv
// Back end: ring storage, sync state machine and result register.
module ebss_back import ebss_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAX_BATCH    = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  req_t  req,
  input  logic  req_valid,
  output logic  req_ready,
  input  cfg_t  cfg,
  ebss_out_if.source out_res
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = IW + 1;
  localparam int SW = $clog2(MAX_BATCH + 1);
  localparam int DW = 32 + PAYLOAD_BITS;
  localparam logic [5:0] MAXB = 6'(MAX_BATCH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_SFIN, S_PLOOP, S_PNEXT, S_EMIT, S_PFIN, S_STATUS
  } state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [31:0]             conf_r;
  logic [31:0]             now_r;
  logic [5:0]              link_r;
  logic [2:0]              sel_r;
  logic [IW-1:0]           wr_r;
  logic [IW-1:0]           rd_r;
  logic [31:0]             seq_ctr_r;
  mode_t                   mode_r;
  logic [32:0]             cursor_r;
  logic [31:0]             end_r;
  logic [SW-1:0]           sib_r;
  logic [SW-1:0]           sent_r;
  logic [7:0]              retries_r;
  logic [31:0]             last_act_r;
  logic [31:0]             counters_r [NUM_CNT];
  logic [CW-1:0]           i_r;
  logic [IW-1:0]           p_r;
  logic                    found_r;
  logic [CW-1:0]           first_i_r;
  logic [31:0]             last_s_r;
  logic [31:0]             best_r;
  logic [PAYLOAD_BITS-1:0] best_data_r;
  logic                    status_r;
  logic [31:0]             value_r;

  logic                    out_valid_r;
  logic                    out_kind_r;
  logic [31:0]             out_seq_r;
  logic [63:0]             out_data_r;
  logic [2:0]              out_state_r;
  logic                    out_status_r;
  logic [31:0]             out_value_r;
  logic [3:0]              out_pending_r;
  logic [31:0]             out_newest_r;
  logic [31:0]             out_stat_r;
  logic                    out_last_r;

  logic [CW-1:0]           cnt;
  logic                    full;
  logic                    slot_free;
  logic                    out_load;
  logic [5:0]              limit;
  logic                    ram_we;
  logic [DW-1:0]           ram_rdata;
  logic [31:0]             s_rd;
  logic [PAYLOAD_BITS-1:0] d_rd;
  logic [7:0]              ret_inc;
  logic [31:0]             newest;
  logic [31:0]             stat;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
    return (x == IW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  assign cnt = (wr_r >= rd_r) ? CW'(wr_r) - CW'(rd_r)
                              : CW'(wr_r) + CW'(QUEUE_DEPTH) - CW'(rd_r);
  assign full      = (cnt == CW'(QUEUE_DEPTH - 1));
  assign slot_free = !out_valid_r || out_res.ready;
  assign out_load  = ((state_r == S_EMIT) || (state_r == S_STATUS)) && slot_free;
  assign limit     = (cfg.burst_cap < MAXB) ? cfg.burst_cap : MAXB;
  assign ram_we    = (state_r == S_IDLE) && req_valid && (req.op == OP_QUEUE);
  assign req_ready = (state_r == S_IDLE);
  assign s_rd      = ram_rdata[DW-1 -: 32];
  assign d_rd      = ram_rdata[PAYLOAD_BITS-1:0];
  assign ret_inc   = (retries_r == 8'hFF) ? retries_r : retries_r + 8'd1;
  assign newest    = (seq_ctr_r == 32'd0) ? 32'd0 : seq_ctr_r - 32'd1;
  assign stat      = (sel_r < 3'(NUM_CNT)) ? counters_r[sel_r] : 32'd0;

  ebss_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata ({seq_ctr_r, req.payload[PAYLOAD_BITS-1:0]}),
    .raddr (p_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      seq_ctr_r   <= 32'd1;
      mode_r      <= MODE_IDLE;
      cursor_r    <= '0;
      end_r       <= '0;
      sib_r       <= '0;
      sent_r      <= '0;
      retries_r   <= '0;
      last_act_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CNT; k++) begin
        counters_r[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            op_r     <= req.op;
            conf_r   <= req.conf;
            now_r    <= req.now;
            link_r   <= req.link;
            sel_r    <= req.sel;
            status_r <= (req.op == OP_ACK) && (mode_r != MODE_WAIT_ACK);
            value_r  <= (req.op == OP_QUEUE) ? seq_ctr_r : '0;
            if (req.op == OP_START) begin
              state_r <= S_RD;
            end else if (req.op == OP_PROCESS && mode_r == MODE_SENDING) begin
              state_r <= S_PLOOP;
            end else begin
              state_r <= S_STATUS;
            end
            unique case (req.op)
              OP_QUEUE: begin
                if (full) begin
                  rd_r <= inc_idx(rd_r);
                  counters_r[CNT_DROPPED] <= counters_r[CNT_DROPPED] + 32'd1;
                end
                wr_r      <= inc_idx(wr_r);
                counters_r[CNT_QUEUED] <= counters_r[CNT_QUEUED] + 32'd1;
                seq_ctr_r <= seq_ctr_r + 32'd1;
              end
              OP_START: begin
                i_r     <= '0;
                p_r     <= rd_r;
                found_r <= 1'b0;
              end
              OP_PROCESS: begin
                if (mode_r == MODE_SENDING) begin
                  sent_r <= '0;
                end else if (mode_r == MODE_WAIT_ACK &&
                             (req.now - last_act_r) > cfg.timeout_ms) begin
                  retries_r <= ret_inc;
                  counters_r[CNT_RETRIES] <= counters_r[CNT_RETRIES] + 32'd1;
                  if (ret_inc >= cfg.max_retries) begin
                    mode_r <= MODE_ERROR;
                    counters_r[CNT_ERRORS] <= counters_r[CNT_ERRORS] + 32'd1;
                  end else begin
                    cursor_r   <= (cursor_r >= 33'(sib_r)) ? cursor_r - 33'(sib_r)
                                                           : '0;
                    mode_r     <= MODE_SENDING;
                    last_act_r <= req.now;
                  end
                end
              end
              OP_ACK: begin
                if (mode_r == MODE_WAIT_ACK) begin
                  retries_r <= '0;
                  if (cursor_r > {1'b0, end_r} && req.ack >= 16'(sib_r)) begin
                    rd_r   <= wr_r;
                    mode_r <= MODE_DONE;
                    counters_r[CNT_SYNCS] <= counters_r[CNT_SYNCS] + 32'd1;
                  end else begin
                    mode_r     <= MODE_SENDING;
                    last_act_r <= req.now;
                  end
                end
              end
              OP_DISC: begin
                mode_r    <= MODE_IDLE;
                sib_r     <= '0;
                retries_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          if (i_r == cnt) begin
            state_r <= (op_r == OP_START) ? S_SFIN : S_PNEXT;
          end else begin
            state_r <= S_EV;
          end
        end
        S_EV: begin
          if (op_r == OP_START) begin
            if (!found_r && s_rd > conf_r) begin
              found_r   <= 1'b1;
              first_i_r <= i_r;
            end
            last_s_r <= s_rd;
          end else if ({1'b0, s_rd} >= cursor_r && s_rd <= end_r &&
                       (!found_r || s_rd < best_r)) begin
            found_r     <= 1'b1;
            best_r      <= s_rd;
            best_data_r <= d_rd;
          end
          i_r     <= i_r + 1'b1;
          p_r     <= inc_idx(p_r);
          state_r <= S_RD;
        end
        S_SFIN: begin
          if (!found_r) begin
            mode_r <= MODE_DONE;
            counters_r[CNT_SYNCS] <= counters_r[CNT_SYNCS] + 32'd1;
          end else begin
            value_r    <= 32'(cnt - first_i_r);
            mode_r     <= MODE_SENDING;
            cursor_r   <= {1'b0, conf_r} + 33'd1;
            end_r      <= last_s_r;
            sib_r      <= '0;
            retries_r  <= '0;
            last_act_r <= now_r;
          end
          state_r <= S_STATUS;
        end
        S_PLOOP: begin
          if (6'(sent_r) < limit && cursor_r <= {1'b0, end_r}) begin
            i_r     <= '0;
            p_r     <= rd_r;
            found_r <= 1'b0;
            state_r <= S_RD;
          end else begin
            state_r <= S_PFIN;
          end
        end
        S_PNEXT: begin
          if (!found_r) begin
            cursor_r <= {1'b0, end_r} + 33'd1;
            state_r  <= S_PFIN;
          end else begin
            cursor_r <= {1'b0, best_r};
            state_r  <= (6'(sent_r) >= link_r) ? S_PFIN : S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_kind_r    <= 1'b1;
            out_seq_r     <= best_r;
            out_data_r    <= 64'(best_data_r);
            out_state_r   <= '0;
            out_status_r  <= 1'b0;
            out_value_r   <= '0;
            out_pending_r <= '0;
            out_newest_r  <= '0;
            out_stat_r    <= '0;
            out_last_r    <= 1'b0;
            sent_r        <= sent_r + 1'b1;
            cursor_r      <= {1'b0, best_r} + 33'd1;
            counters_r[CNT_SYNCED] <= counters_r[CNT_SYNCED] + 32'd1;
            state_r       <= S_PLOOP;
          end
        end
        S_PFIN: begin
          sib_r <= sent_r;
          if (sent_r != '0) begin
            mode_r     <= MODE_WAIT_ACK;
            last_act_r <= now_r;
          end else if (cursor_r > {1'b0, end_r}) begin
            mode_r <= MODE_DONE;
            counters_r[CNT_SYNCS] <= counters_r[CNT_SYNCS] + 32'd1;
          end else begin
            mode_r <= MODE_ERROR;
            counters_r[CNT_ERRORS] <= counters_r[CNT_ERRORS] + 32'd1;
          end
          state_r <= S_STATUS;
        end
        S_STATUS: begin
          if (slot_free) begin
            out_kind_r    <= 1'b0;
            out_seq_r     <= '0;
            out_data_r    <= '0;
            out_state_r   <= mode_r;
            out_status_r  <= status_r;
            out_value_r   <= value_r;
            out_pending_r <= 4'(cnt);
            out_newest_r  <= newest;
            out_stat_r    <= stat;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.item_kind  = out_kind_r;
  assign out_res.event_seq  = out_seq_r;
  assign out_res.event_data = out_data_r;
  assign out_res.sync_state = out_state_r;
  assign out_res.status     = out_status_r;
  assign out_res.value      = out_value_r;
  assign out_res.pending    = out_pending_r;
  assign out_res.newest_seq = out_newest_r;
  assign out_res.stat_value = out_stat_r;
  assign out_res.last       = out_last_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wr_r) < QUEUE_DEPTH) && (32'(rd_r) < QUEUE_DEPTH))
    else $error("ring index out of range");
  a_sent_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sent_r) <= MAX_BATCH)
    else $error("batch count above maximum");
  a_wait_sent: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_WAIT_ACK |-> sib_r != '0)
    else $error("waiting for acknowledge with empty batch");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |-> out_last_r && out_seq_r == 32'd0)
    else $error("status item malformed");
`endif
endmodule

// File: sv/event_batch_sync_sender_unit.sv
// Top level of the event batch sync sender: configuration, front and back end.
//
//   channel   direction  handshake     contents
//   in_req    in         valid/ready   one command request
//   out_res   out        valid/ready   emitted events, then one status item
//   cfg_*     in         write enable  batch size, timeout, retry limit
//
// Queue, acknowledge, disconnect and process outside sending go from idle straight to the status item.
// A start scans the ring, reading each stored event in turn.
// A sending pass scans the ring for each event it emits, the RAM read port
// being shared by all scans.
// Reset is synchronous; the ring RAM holds no reset and needs no clearing.
// Two requests queue in the front end while the back end or the result
// register is stalled.
module event_batch_sync_sender_unit import ebss_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAX_BATCH    = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ebss_in_if.sink     in_req,
  ebss_out_if.source  out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  cfg_t cfg_r;
  req_t req;
  logic req_valid;
  logic req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst_cap   <= 6'd8;
      cfg_r.timeout_ms  <= 32'd1000;
      cfg_r.max_retries <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURST_CAP:   cfg_r.burst_cap   <= cfg_wdata[5:0];
        CFG_TIMEOUT_MS:  cfg_r.timeout_ms  <= cfg_wdata;
        CFG_MAX_RETRIES: cfg_r.max_retries <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  ebss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready)
  );

  ebss_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_BATCH    (MAX_BATCH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cfg       (cfg_r),
    .out_res   (out_res)
  );
endmodule

// File: verif/testbench.sv
// Self-checking testbench for the event batch sync sender.
`timescale 1ns / 100ps

module testbench;
  import ebss_pkg::*;

  localparam int LIMIT = 1500000;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] payload;
    logic [31:0] conf;
    logic [15:0] ack;
    logic [31:0] now;
    logic [5:0]  link;
    logic [2:0]  sel;
  } request_t;

  typedef struct {
    logic        kind;
    logic [31:0] seq;
    logic [63:0] data;
    logic [2:0]  state;
    logic        status;
    logic [31:0] value;
    logic [3:0]  pending;
    logic [31:0] newest;
    logic [31:0] stat;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  ebss_in_if  in_req ();
  ebss_out_if out_res ();

  event_batch_sync_sender_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  request_t    waiting_reqs[$];
  result_t     due_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          idle_in = 1'b1;
  bit          idle_out = 1'b1;
  int          sent_count = 0;
  int          recv_count = 0;

  // Predicted sender state.
  logic [31:0] seq_mem [16];
  logic [63:0] pay_mem [16];
  logic [3:0]  wr_ptr = '0;
  logic [3:0]  rd_ptr = '0;
  logic [31:0] seq_ctr = 32'd1;
  mode_t       mode = MODE_IDLE;
  logic [32:0] cursor = '0;
  logic [31:0] end_seq = '0;
  logic [15:0] burst_len = '0;
  logic [7:0]  retries = '0;
  logic [31:0] last_act = '0;
  logic [31:0] stats [NUM_CNT] = '{default: '0};
  logic [5:0]  burst_cap = 6'd8;
  logic [31:0] timeout_ms = 32'd1000;
  logic [7:0]  max_retries = 8'd3;

  // Generator bookkeeping.
  logic [31:0] gen_newest = '0;
  logic [31:0] gen_now = '0;

  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  task automatic sync_sender_predict(input request_t r);
    logic [3:0]  fill;
    logic [3:0]  pos;
    logic [31:0] s;
    logic [31:0] best;
    logic [3:0]  bpos;
    logic [31:0] elapsed;
    logic [31:0] value;
    logic        status;
    logic        found;
    int          idx;
    int          limit;
    int          sent;
    result_t     res;
    value = '0;
    status = 1'b0;
    fill = wr_ptr - rd_ptr;
    case (r.cmd)
      CMD_QUEUE: begin
        if (fill == 4'd15) begin
          rd_ptr = rd_ptr + 4'd1;
          stats[CNT_DROPPED]++;
        end
        seq_mem[wr_ptr] = seq_ctr;
        pay_mem[wr_ptr] = r.payload;
        wr_ptr = wr_ptr + 4'd1;
        stats[CNT_QUEUED]++;
        value = seq_ctr;
        seq_ctr = seq_ctr + 32'd1;
      end
      CMD_START: begin
        idx = int'(fill);
        for (int k = 0; k < fill; k++) begin
          pos = rd_ptr + 4'(k);
          if (idx == fill && seq_mem[pos] > r.conf) idx = k;
        end
        if (idx == fill) begin
          mode = MODE_DONE;
          stats[CNT_SYNCS]++;
        end else begin
          value = 32'(int'(fill) - idx);
          mode = MODE_SENDING;
          cursor = {1'b0, r.conf} + 33'd1;
          end_seq = seq_mem[rd_ptr + fill - 4'd1];
          burst_len = '0;
          retries = '0;
          last_act = r.now;
        end
      end
      CMD_PROCESS: begin
        if (mode == MODE_SENDING) begin
          limit = burst_cap < 32 ? int'(burst_cap) : 32;
          sent = 0;
          while (sent < limit && cursor <= {1'b0, end_seq}) begin
            found = 1'b0;
            best = '0;
            bpos = '0;
            for (int k = 0; k < fill; k++) begin
              pos = rd_ptr + 4'(k);
              s = seq_mem[pos];
              if ({1'b0, s} >= cursor && s <= end_seq && (!found || s < best)) begin
                found = 1'b1;
                best = s;
                bpos = pos;
              end
            end
            if (!found) begin
              cursor = {1'b0, end_seq} + 33'd1;
              break;
            end
            cursor = {1'b0, best};
            if (sent >= r.link) break;
            res = '{1'b1, best, pay_mem[bpos], 3'd0, 1'b0, 32'd0, 4'd0, 32'd0, 32'd0, 1'b0};
            due_results.push_back(res);
            sent++;
            cursor = cursor + 33'd1;
            stats[CNT_SYNCED]++;
          end
          burst_len = 16'(sent);
          if (sent > 0) begin
            mode = MODE_WAIT_ACK;
            last_act = r.now;
          end else if (cursor > {1'b0, end_seq}) begin
            mode = MODE_DONE;
            stats[CNT_SYNCS]++;
          end else begin
            mode = MODE_ERROR;
            stats[CNT_ERRORS]++;
          end
        end else if (mode == MODE_WAIT_ACK) begin
          elapsed = r.now - last_act;
          if (elapsed > timeout_ms) begin
            if (retries < 8'd255) retries = retries + 8'd1;
            stats[CNT_RETRIES]++;
            if (retries >= max_retries) begin
              mode = MODE_ERROR;
              stats[CNT_ERRORS]++;
            end else begin
              cursor = cursor >= 33'(burst_len) ? cursor - 33'(burst_len) : '0;
              mode = MODE_SENDING;
              last_act = r.now;
            end
          end
        end
      end
      CMD_ACK: begin
        if (mode != MODE_WAIT_ACK) begin
          status = 1'b1;
        end else begin
          retries = '0;
          if (cursor > {1'b0, end_seq} && r.ack >= burst_len) begin
            rd_ptr = wr_ptr;
            mode = MODE_DONE;
            stats[CNT_SYNCS]++;
          end else begin
            mode = MODE_SENDING;
            last_act = r.now;
          end
        end
      end
      CMD_DISC: begin
        mode = MODE_IDLE;
        burst_len = '0;
        retries = '0;
      end
      default: begin
      end
    endcase
    res = '{1'b0, 32'd0, 64'd0, mode, status, value, wr_ptr - rd_ptr,
            seq_ctr == 0 ? 32'd0 : seq_ctr - 32'd1,
            r.sel < 6 ? stats[r.sel] : 32'd0, 1'b1};
    due_results.push_back(res);
  endtask

  task automatic add_req(input logic [2:0] cmd, input logic [63:0] pl,
                         input logic [31:0] conf, input logic [15:0] ack,
                         input logic [31:0] now, input logic [5:0] link,
                         input logic [2:0] sel);
    request_t r;
    r = '{cmd, pl, conf, ack, now, link, sel};
    if (cmd == CMD_QUEUE) gen_newest = gen_newest + 32'd1;
    waiting_reqs.push_back(r);
  endtask

  function automatic logic [2:0] any_sel();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [63:0] any_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic add_session();
    int          nq;
    int          rounds;
    logic [31:0] conf;
    logic [5:0]  link;
    nq = $urandom_range(0, 6);
    repeat (nq) begin
      gen_now = gen_now + $urandom_range(0, 50);
      add_req(CMD_QUEUE, any_payload(), $urandom, 16'($urandom), gen_now, 6'd32,
              any_sel());
    end
    case ($urandom_range(0, 9))
      0: conf = $urandom;
      1: conf = 32'hFFFF_FFFF;
      2: conf = 32'd0;
      default: conf = gen_newest - $urandom_range(1, 18);
    endcase
    add_req(CMD_START, any_payload(), conf, 16'($urandom), gen_now, 6'd32, any_sel());
    rounds = $urandom_range(1, 6);
    repeat (rounds) begin
      link = $urandom_range(0, 9) < 7 ? 6'd32 : 6'($urandom_range(0, 32));
      gen_now = gen_now + $urandom_range(0, 50);
      add_req(CMD_PROCESS, any_payload(), $urandom, 16'($urandom), gen_now, link,
              any_sel());
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          gen_now = gen_now + $urandom_range(0, 50);
          add_req(CMD_ACK, any_payload(), $urandom,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
                  gen_now, link, any_sel());
        end
        3, 4: begin
          if (timeout_ms < 32'hFFFF_0000) gen_now = gen_now + timeout_ms + $urandom_range(1, 100);
          else gen_now = $urandom;
        end
        default: begin
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      add_req(CMD_DISC, any_payload(), $urandom, 16'($urandom), gen_now, 6'd32, any_sel());
    if ($urandom_range(0, 2) == 0)
      add_req(3'($urandom_range(0, 7)), any_payload(), $urandom, 16'($urandom), $urandom,
              6'($urandom_range(0, 32)), any_sel());
  endtask

  task automatic add_random_phase(input int count);
    int target;
    target = waiting_reqs.size() + count;
    while (waiting_reqs.size() < target) add_session();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BURST_CAP: burst_cap = data[5:0];
      CFG_TIMEOUT_MS: timeout_ms = data;
      default: max_retries = data[7:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (waiting_reqs.size() != 0 || in_req.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic phase_config(input logic [5:0] bm, input logic [31:0] tmo,
                              input logic [7:0] mr);
    wait_idle();
    write_reg(CFG_BURST_CAP, {26'd0, bm});
    write_reg(CFG_TIMEOUT_MS, tmo);
    write_reg(CFG_MAX_RETRIES, {24'd0, mr});
  endtask

  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (in_req.valid && !in_fire) begin
    end else if (in_gap > 0) begin
      in_req.valid <= 1'b0;
      in_gap--;
    end else if (waiting_reqs.size() > 0) begin
      r = waiting_reqs.pop_front();
      in_req.valid <= 1'b1;
      in_req.command <= r.cmd;
      in_req.event_payload <= r.payload;
      in_req.confirmed_seq <= r.conf;
      in_req.ack_count <= r.ack;
      in_req.now_ms <= r.now;
      in_req.link_accepts <= r.link;
      in_req.stat_select <= r.sel;
      sent_count++;
      if (sent_count % 20 == 0) idle_in = $urandom_range(0, 3) != 0;
      in_gap = idle_in ? $urandom_range(0, 14) : 0;
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        recv_count++;
        if (recv_count % 25 == 0) idle_out = $urandom_range(0, 3) != 0;
        out_stall = idle_out ? $urandom_range(0, 14) : 0;
      end
      if (out_stall > 0) begin
        out_res.ready <= 1'b0;
        out_stall--;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    request_t r;
    result_t  got;
    result_t  want;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    in_fire <= rst_n && in_req.valid && in_req.ready;
    out_fire <= rst_n && out_res.valid && out_res.ready;
    if (rst_n && in_req.valid && in_req.ready) begin
      r = '{in_req.command, in_req.event_payload, in_req.confirmed_seq, in_req.ack_count,
            in_req.now_ms, in_req.link_accepts, in_req.stat_select};
      sync_sender_predict(r);
    end
    if (rst_n && out_res.valid && out_res.ready) begin
      got = '{out_res.item_kind, out_res.event_seq, out_res.event_data, out_res.sync_state,
              out_res.status, out_res.value, out_res.pending, out_res.newest_seq,
              out_res.stat_value, out_res.last};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = due_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Commands with nothing to work on, unknown commands and selectors, then four queued events.
    add_req(CMD_ACK, '0, '0, '0, '0, 6'd0, 3'd0);
    add_req(CMD_PROCESS, '0, '0, '0, '0, 6'd0, 3'd1);
    add_req(CMD_START, '0, '0, '0, '0, 6'd0, 3'd3);
    add_req(3'd5, '1, '1, '1, '1, 6'd32, 3'd6);
    add_req(3'd6, '0, '0, '0, '0, 6'd0, 3'd7);
    add_req(3'd7, '1, '1, '1, '1, 6'd63, 3'd2);
    add_req(CMD_QUEUE, 64'd0, '0, '0, 32'd10, 6'd0, 3'd1);
    add_req(CMD_QUEUE, '1, '0, '0, 32'd10, 6'd0, 3'd1);
    add_req(CMD_QUEUE, {32{2'b10}}, '0, '0, 32'd10, 6'd0, 3'd1);
    add_req(CMD_QUEUE, {32{2'b01}}, '0, '0, 32'd10, 6'd0, 3'd1);
    // A refusing link leaves the sync in error.
    add_req(CMD_START, '0, 32'd0, '0, 32'd20, 6'd0, 3'd3);
    add_req(CMD_PROCESS, '0, '0, '0, 32'd20, 6'd0, 3'd4);
    add_req(CMD_DISC, '0, '0, '0, 32'd20, 6'd0, 3'd0);
    // Start beyond the newest event finishes at once.
    add_req(CMD_START, '0, 32'hFFFF_FFFF, '0, 32'd30, 6'd32, 3'd3);
    add_req(CMD_START, '0, 32'd1, '0, 32'd40, 6'd32, 3'd2);
    add_req(CMD_PROCESS, '0, '0, '0, 32'd40, 6'd32, 3'd2);
    add_req(CMD_ACK, '0, '0, 16'd0, 32'd50, 6'd32, 3'd3);
    add_req(CMD_PROCESS, '0, '0, '0, 32'd60, 6'd32, 3'd3);
    add_req(CMD_START, '0, 32'd0, '0, 32'd100, 6'd32, 3'd3);
    add_req(CMD_PROCESS, '0, '0, '0, 32'd100, 6'd2, 3'd2);
    // Timeouts that send the batch again, short of the retry limit.
    add_req(CMD_PROCESS, '0, '0, '0, 32'd2000, 6'd32, 3'd5);
    add_req(CMD_PROCESS, '0, '0, '0, 32'd2000, 6'd32, 3'd5);
    add_req(CMD_PROCESS, '0, '0, '0, 32'hFFFF_FFFF, 6'd32, 3'd5);
    add_req(CMD_ACK, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, 6'd32, 3'd4);
    gen_now = 32'd5000;
    add_random_phase(60);

    phase_config(6'd1, 32'd0, 8'd1);
    add_random_phase(60);
    phase_config(6'd32, 32'hFFFF_FFFF, 8'd255);
    add_random_phase(60);
    phase_config(6'($urandom_range(1, 32)), $urandom_range(0, 3000),
                 8'($urandom_range(1, 8)));
    add_random_phase(60);

    wait_idle();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ebss_pkg.sv
sv/ebss_in_if.sv
sv/ebss_out_if.sv
sv/ebss_ram.sv
sv/ebss_front.sv
sv/ebss_back.sv
sv/event_batch_sync_sender_unit.sv
verif/testbench.sv
